// ===== sv/ucs_pkg.sv =====
// Shared types and constants for the UTF-8 character segmenter.
// No dependencies; used by ucs_step and utf8_char_segmenter.
package ucs_pkg;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_BADLEAD = 3'd4;
    localparam logic [2:0] ERR_DISCARD = 3'd5;

    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    typedef struct packed {
        logic [1:0] remaining;
        logic [2:0] cur_len;
        logic       failed;
    } t_state;

    localparam t_state STATE_CLEAR = '{remaining: 2'd0, cur_len: 3'd1, failed: 1'b0};

    typedef struct packed {
        logic [7:0] byte_out;
        logic       char_start;
        logic       char_end;
        logic [2:0] char_length;
        logic [2:0] error_code;
        logic       string_done;
    } t_result;

endpackage

// ===== sv/ucs_step.sv =====
// Per-byte segmentation logic: one result and the next state from one byte.
// Depends on ucs_pkg.
module ucs_step (
    input  logic [7:0]      i_byte,
    input  logic            i_eos,
    input  ucs_pkg::t_state i_state,
    output ucs_pkg::t_result o_result,
    output ucs_pkg::t_state o_state
);

    logic [2:0] lead_len;
    logic       is_cont;
    logic [1:0] rem_dec;

    always_comb begin
        priority if ((i_byte & ucs_pkg::LEAD1_MASK) == 8'h00) begin
            lead_len = 3'd1;
        end else if ((i_byte & ucs_pkg::LEAD2_MASK) == ucs_pkg::LEAD2_CODE) begin
            lead_len = 3'd2;
        end else if ((i_byte & ucs_pkg::LEAD3_MASK) == ucs_pkg::LEAD3_CODE) begin
            lead_len = 3'd3;
        end else if ((i_byte & ucs_pkg::LEAD4_MASK) == ucs_pkg::LEAD4_CODE) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    assign is_cont = (i_byte & ucs_pkg::CONT_MASK) == ucs_pkg::CONT_CODE;
    assign rem_dec = i_state.remaining - 2'd1;

    always_comb begin
        o_result.byte_out    = i_byte;
        o_result.char_start  = 1'b0;
        o_result.char_end    = 1'b0;
        o_result.char_length = 3'd1;
        o_result.error_code  = ucs_pkg::ERR_OK;
        o_result.string_done = i_eos;
        o_state              = i_state;

        priority if (i_state.failed) begin
            o_result.error_code = ucs_pkg::ERR_DISCARD;
        end else if (i_state.remaining == 2'd0) begin
            o_result.char_start = 1'b1;
            priority if (lead_len == 3'd0) begin
                o_result.error_code = ucs_pkg::ERR_BADLEAD;
                o_state.failed      = 1'b1;
            end else if (lead_len == 3'd1) begin
                o_result.char_end = 1'b1;
            end else begin
                o_result.char_length = lead_len;
                o_state.cur_len      = lead_len;
                o_state.remaining    = 2'(lead_len - 3'd1);
                if (i_eos) begin
                    o_result.error_code = lead_len - 3'd1;
                end
            end
        end else begin
            o_result.char_length = i_state.cur_len;
            if (is_cont) begin
                o_state.remaining = rem_dec;
                if (rem_dec == 2'd0) begin
                    o_result.char_end = 1'b1;
                    o_state.cur_len   = 3'd1;
                end else if (i_eos) begin
                    o_result.error_code = i_state.cur_len - 3'd1;
                end
            end else begin
                o_result.error_code = i_state.cur_len - 3'd1;
                o_state.failed      = 1'b1;
            end
        end

        if (i_eos) begin
            o_state = ucs_pkg::STATE_CLEAR;
        end
    end

endmodule

// ===== sv/utf8_char_segmenter.sv =====
// UTF-8 character segmenter top level: input register, step logic, result register.
// Depends on ucs_pkg and ucs_step.
// Input register, then ucs_step, then result register; character state updates once per byte.
// Throughput: one byte per cycle while the output is not stalled by i_ready low.
// Reset: synchronous active-low i_rst_n empties both registers and clears the
// character state to the start of a new string.
module utf8_char_segmenter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic       o_char_start,
    output logic       o_char_end,
    output logic [2:0] o_char_length,
    output logic [2:0] o_error_code,
    output logic       o_string_done
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eos;
    logic             r_out_valid;
    ucs_pkg::t_result r_result;
    ucs_pkg::t_state  r_state;

    ucs_pkg::t_result n_result;
    ucs_pkg::t_state  n_state;
    logic             advance;

    ucs_step u_step (
        .i_byte   (r_in_byte),
        .i_eos    (r_in_eos),
        .i_state  (r_state),
        .o_result (n_result),
        .o_state  (n_state)
    );

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ucs_pkg::STATE_CLEAR;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_string;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_byte_out    = r_result.byte_out;
    assign o_char_start  = r_result.char_start;
    assign o_char_end    = r_result.char_end;
    assign o_char_length = r_result.char_length;
    assign o_error_code  = r_result.error_code;
    assign o_string_done = r_result.string_done;

`ifndef SYNTHESIS
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_eos) |=> (r_state == ucs_pkg::STATE_CLEAR))
        else $error("state not cleared after string end");

    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.remaining != 2'd0) |-> ({1'b0, r_state.remaining} < r_state.cur_len))
        else $error("remaining count exceeds character length");

    a_end_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_end) |-> (o_error_code == ucs_pkg::ERR_OK))
        else $error("character end flagged with error");

    a_discard_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ucs_pkg::ERR_DISCARD)
            |-> (!o_char_start && !o_char_end && o_char_length == 3'd1))
        else $error("discarded item carries character marks");
`endif

endmodule
